// File: hw/rtl/trsd_pkg.sv
// ----------------------------------------------------------------------------
// trsd_pkg
// Shared types, register indexes and the run-settling step for the
// transparent run-length sprite decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package trsd_pkg;

   // Byte counter width; the result field shows its low 24 bits.
   localparam int CountBits = 24;

   // Saturation value of the column counter.
   localparam logic [8:0] ColMax = 9'd511;

   // Configuration register indexes.
   localparam logic [7:0] CsrImageWidth  = 8'd0;
   localparam logic [7:0] CsrImageHeight = 8'd1;

   // Position and run state that the settling step touches.
   typedef struct packed {
      logic [7:0] row;
      logic [8:0] col;
      logic [6:0] run;
      logic       leak;
   } walk_type;

   // One result beat.
   typedef struct packed {
      logic        pixel_write;
      logic [15:0] pixel_index;
      logic [7:0]  colour_index;
      logic        image_done;
      logic [23:0] bytes_consumed;
      logic        colour_leak;
      logic        buffer_end;
   } result_type;

   // Resolve one literal slot that needs no byte. After a row wrap the
   // column is zero, so two applications settle any run.
   function automatic walk_type settle_step(walk_type s, logic [7:0] w, logic [7:0] h);
      walk_type nxt;
      nxt = s;
      if (s.run != 7'd0) begin
         if (s.row >= h) begin
            nxt.leak = 1'b1;
            nxt.run  = 7'd0;
         end else if (s.col > {1'b0, w}) begin
            nxt.row  = s.row + 8'd1;
            nxt.col  = 9'd0;
            nxt.leak = 1'b1;
            nxt.run  = s.run - 7'd1;
         end else if (s.col == {1'b0, w}) begin
            nxt.leak = 1'b1;
            nxt.run  = 7'd0;
         end
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/trsd_channels.sv
// ----------------------------------------------------------------------------
// trsd_channels
// Valid/ready channel interfaces for stream bytes, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface trsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       beyond_end;
   logic       first_of_image;

   modport source (output valid, data_byte, beyond_end, first_of_image, input ready);
   modport sink (input valid, data_byte, beyond_end, first_of_image, output ready);
endinterface

interface trsd_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_write;
   logic [15:0] pixel_index;
   logic [7:0]  colour_index;
   logic        image_done;
   logic [23:0] bytes_consumed;
   logic        colour_leak;
   logic        buffer_end;

   modport source (output valid, pixel_write, pixel_index, colour_index, image_done,
                   bytes_consumed, colour_leak, buffer_end, input ready);
   modport sink (input valid, pixel_write, pixel_index, colour_index, image_done,
                 bytes_consumed, colour_leak, buffer_end, output ready);
endinterface

interface trsd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/transparent_rle_sprite_decoder.sv
// A result beat is registered in the output register, or parked in the skid register.
// Throughput: one stream beat per cycle; the whole per-byte update (position, run,
//   settling of slots past the row end, row*width+column multiply) is one register stage.
// A two-entry output (result register plus skid register) keeps input flowing while
//   a result waits; input stalls only when both entries hold results.
// Reset (synchronous, active high) clears all decode state and sets width and height to 1.
// ----------------------------------------------------------------------------
// transparent_rle_sprite_decoder
// Decodes an 8-bit paletted run-length sprite stream with transparent skips
// into pixel writes and a final status beat.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_rle_sprite_decoder (
   input wire logic   clock,
   input wire logic   reset,
   trsd_req_if.sink   req_chan,
   trsd_rsp_if.source rsp_chan,
   trsd_csr_if.sink   csr_chan
);

   // Configuration registers.
   logic [7:0] width_ff;
   logic [7:0] height_ff;

   // Decode state.
   logic [7:0]                    row_ff, row_in;
   logic [8:0]                    col_ff, col_in;
   logic [6:0]                    run_ff, run_in;
   logic [trsd_pkg::CountBits-1:0] count_ff, count_in;
   logic                          leak_ff, leak_in;
   logic                          end_ff, end_in;
   logic                          fin_ff, fin_in;

   // Output register and skid register.
   logic                  rsp_valid_ff;
   trsd_pkg::result_type  rsp_data_ff;
   logic                  skid_valid_ff;
   trsd_pkg::result_type  skid_data_ff;

   logic                  req_fire;
   logic                  slot_free;
   logic                  produce;
   trsd_pkg::result_type  result;

   // Start-of-step position (after a first-of-image clear) feeds the pixel index.
   logic [7:0]  start_row;
   logic [8:0]  start_col;
   logic [15:0] row_product;
   logic [15:0] pixel_index;

   // Step outcome.
   logic wrote;
   logic done;

   // ------------------------------------------------------------------------
   // Configuration: always ready; writes to unknown indexes are dropped.
   // ------------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd1;
         height_ff <= 8'd1;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            trsd_pkg::CsrImageWidth:  width_ff  <= csr_chan.data;
            trsd_pkg::CsrImageHeight: height_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Handshake: accept while the skid entry is empty.
   // ------------------------------------------------------------------------
   assign req_chan.ready = !skid_valid_ff;
   assign req_fire       = req_chan.valid && !skid_valid_ff;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // ------------------------------------------------------------------------
   // Pixel index: row*width + column, wrapped to 16 bits.
   // ------------------------------------------------------------------------
   assign start_row   = req_chan.first_of_image ? 8'd0 : row_ff;
   assign start_col   = req_chan.first_of_image ? 9'd0 : col_ff;
   assign row_product = {8'd0, start_row} * {8'd0, width_ff};
   assign pixel_index = row_product + {7'd0, start_col};

   // ------------------------------------------------------------------------
   // Per-byte decode step.
   // ------------------------------------------------------------------------
   always_comb begin
      trsd_pkg::walk_type walk;
      logic [7:0]         data;
      logic [9:0]         skip_sum;
      logic [trsd_pkg::CountBits-1:0] count;
      logic               end_flag;
      logic               fin;

      data     = req_chan.data_byte;
      skip_sum = 10'd0;
      wrote    = 1'b0;
      done     = 1'b0;

      // A first byte clears everything before it is looked at.
      if (req_chan.first_of_image) begin
         walk     = '0;
         count    = '0;
         end_flag = 1'b0;
         fin      = 1'b0;
      end else begin
         walk.row  = row_ff;
         walk.col  = col_ff;
         walk.run  = run_ff;
         walk.leak = leak_ff;
         count     = count_ff;
         end_flag  = end_ff;
         fin       = fin_ff;
      end

      if (fin) begin
         // Sprite already reported: drop the byte silently.
      end else if (walk.row >= height_ff) begin
         // Rows done on entry: report without taking the byte, drop any run.
         if (walk.run != 7'd0) begin
            walk.leak = 1'b1;
            walk.run  = 7'd0;
         end
         fin  = 1'b1;
         done = 1'b1;
      end else begin
         if (count != '1) begin
            count = count + {{(trsd_pkg::CountBits-1){1'b0}}, 1'b1};
         end
         if (req_chan.beyond_end) begin
            end_flag = 1'b1;
            data     = 8'd0;
         end

         if (walk.run != 7'd0) begin
            // Literal slot: a byte past the buffer fills it without a write.
            walk.run = walk.run - 7'd1;
            wrote    = !req_chan.beyond_end;
            if (walk.col < trsd_pkg::ColMax) begin
               walk.col = walk.col + 9'd1;
            end
         end else if (data[7]) begin
            // Transparent skip of 256 - data columns, saturating.
            skip_sum = {1'b0, walk.col} + (10'd256 - {2'd0, data});
            if (skip_sum > {1'b0, trsd_pkg::ColMax}) begin
               walk.col = trsd_pkg::ColMax;
            end else begin
               walk.col = skip_sum[8:0];
            end
         end else if (data == 8'd0) begin
            walk.col = 9'd0;
            walk.row = walk.row + 8'd1;
         end else begin
            walk.run = data[6:0];
         end

         // Settle slots past the row end: at most a wrap then a stop.
         walk = trsd_pkg::settle_step(walk, width_ff, height_ff);
         walk = trsd_pkg::settle_step(walk, width_ff, height_ff);

         if (!wrote && walk.run == 7'd0 && walk.row >= height_ff) begin
            fin  = 1'b1;
            done = 1'b1;
         end
      end

      row_in   = walk.row;
      col_in   = walk.col;
      run_in   = walk.run;
      leak_in  = walk.leak;
      count_in = count;
      end_in   = end_flag;
      fin_in   = fin;

      result.pixel_write    = wrote;
      result.pixel_index    = wrote ? pixel_index : 16'd0;
      result.colour_index   = wrote ? data : 8'd0;
      result.image_done     = done;
      result.bytes_consumed = 24'(count);
      result.colour_leak    = walk.leak;
      result.buffer_end     = end_flag;
   end

   assign produce = req_fire && (wrote || done);

   // Advance decode state on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= 8'd0;
         col_ff   <= 9'd0;
         run_ff   <= 7'd0;
         count_ff <= '0;
         leak_ff  <= 1'b0;
         end_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else if (req_fire) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         run_ff   <= run_in;
         count_ff <= count_in;
         leak_ff  <= leak_in;
         end_ff   <= end_in;
         fin_ff   <= fin_in;
      end
   end

   // ------------------------------------------------------------------------
   // Output register with skid: hold a stalled beat, park a new one behind it.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (slot_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= produce;
         end else begin
            rsp_valid_ff <= produce;
         end
      end else if (produce) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         if (skid_valid_ff) begin
            rsp_data_ff  <= skid_data_ff;
            skid_data_ff <= result;
         end else begin
            rsp_data_ff <= result;
         end
      end else if (produce) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pixel_write    = rsp_data_ff.pixel_write;
   assign rsp_chan.pixel_index    = rsp_data_ff.pixel_index;
   assign rsp_chan.colour_index   = rsp_data_ff.colour_index;
   assign rsp_chan.image_done     = rsp_data_ff.image_done;
   assign rsp_chan.bytes_consumed = rsp_data_ff.bytes_consumed;
   assign rsp_chan.colour_leak    = rsp_data_ff.colour_leak;
   assign rsp_chan.buffer_end     = rsp_data_ff.buffer_end;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a beat while the output register is empty");

   stall_parks_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && produce) |=> skid_valid_ff)
      else $error("result produced under stall was not parked");

   done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (produce && done) |=> fin_ff)
      else $error("final beat issued without marking the sprite finished");

   finished_is_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && fin_ff && !req_chan.first_of_image) |-> !produce)
      else $error("result produced after the sprite was finished");

   write_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.pixel_write && rsp_data_ff.image_done))
      else $error("beat is both a pixel write and the final beat");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the transparent run-length sprite decoder. Stream
// bytes go in through the request channel and every result beat is matched,
// field by field, against a cycle-free decoder model kept in the bench.
// A short scripted part walks reset values, extremes and the odd cases;
// randomly shaped sprites with random stalls on both sides then follow.
// ----------------------------------------------------------------------------
module tb;

   // Stream bytes wanted from the random part.
   localparam int StreamTarget = 1450;
   // Idle chance, in percent, on either side outside the calm stretch.
   localparam int IdlePercent = 19;

   logic clock;
   logic reset;

   trsd_req_if req_bus();
   trsd_rsp_if rsp_bus();
   trsd_csr_if csr_bus();

   transparent_rle_sprite_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // 20 ns period: low half, then high half.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // --------------------------------------------------------------------------
   // Types
   // --------------------------------------------------------------------------
   typedef struct packed {
      logic [7:0] data;
      logic       beyond;
      logic       first;
   } stream_beat_type;

   // Decoder walk state: position, pending literal slots, byte count, flags.
   typedef struct packed {
      logic [7:0]                     row;
      logic [8:0]                     col;
      logic [6:0]                     run;
      logic [trsd_pkg::CountBits-1:0] count;
      logic                           leak;
      logic                           ended;
      logic                           done;
   } sprite_walk_type;

   // Script rows: a stream byte checked by the model, a stream byte whose
   // outcome is typed in (no beat, or a given beat), or a register write.
   typedef enum {
      ROW_PREDICT,
      ROW_QUIET,
      ROW_KNOWN,
      ROW_SET_WIDTH,
      ROW_SET_HEIGHT
   } row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [7:0]           data;
      logic                 beyond;
      logic                 first;
      trsd_pkg::result_type want;
   } plan_row_type;

   typedef enum {
      SPRITE_CLEAN,
      SPRITE_OVERRUN,
      SPRITE_TRUNCATED,
      SPRITE_NOISE
   } sprite_style_type;

   // --------------------------------------------------------------------------
   // Bench state
   // --------------------------------------------------------------------------
   logic [7:0]           img_width;
   logic [7:0]           img_height;
   sprite_walk_type      sprite;
   trsd_pkg::result_type owed[$];        // result beats still to come, oldest first
   plan_row_type         script[$];
   stream_beat_type      burst[$];       // bytes of the sprite being sent
   int                   live_beats;     // accepted stream beats
   int                   beats_taken;    // result beats accepted
   int                   mismatches;
   bit                   calm;           // both sides stop idling while set

   // --------------------------------------------------------------------------
   // Helpers
   // --------------------------------------------------------------------------
   function automatic stream_beat_type beat_of(int d, bit beyond, bit first);
      return {8'(d), beyond, first};
   endfunction

   function automatic trsd_pkg::result_type make_beat(bit write, int idx, int colour,
                                                      bit done, int count, bit leak,
                                                      bit ended);
      trsd_pkg::result_type r;
      r.pixel_write    = write;
      r.pixel_index    = 16'(idx);
      r.colour_index   = 8'(colour);
      r.image_done     = done;
      r.bytes_consumed = 24'(count);
      r.colour_leak    = leak;
      r.buffer_end     = ended;
      return r;
   endfunction

   // Advance the decoder model by one stream byte. Returns 1 when the byte
   // yields a result beat.
   function automatic bit decode_byte(input stream_beat_type b,
                                      output trsd_pkg::result_type res);
      logic [7:0] d;
      bit         wrote;
      int         pos;
      int         skip_to;
      d       = b.data;
      wrote   = 1'b0;
      pos     = 0;
      res     = '0;
      if (b.first) sprite = '0;
      if (sprite.done) begin
         return 1'b0;
      end
      // Rows already complete on entry: report at once, take no byte.
      if (sprite.row >= img_height) begin
         if (sprite.run != 7'd0) begin
            sprite.leak = 1'b1;
            sprite.run  = 7'd0;
         end
         sprite.done = 1'b1;
         res = make_beat(1'b0, 0, 0, 1'b1, int'(sprite.count[23:0]), sprite.leak,
                         sprite.ended);
         return 1'b1;
      end

      if (sprite.count != {trsd_pkg::CountBits{1'b1}}) sprite.count++;
      if (b.beyond) begin
         sprite.ended = 1'b1;
         d = 8'd0;
      end

      if (sprite.run != 7'd0) begin
         // Literal slot: a byte past the buffer fills it without a write.
         sprite.run--;
         if (!b.beyond) begin
            wrote = 1'b1;
            pos   = int'(sprite.row) * int'(img_width) + int'(sprite.col);
         end
         if (sprite.col < trsd_pkg::ColMax) sprite.col++;
      end else if (d[7]) begin
         skip_to    = int'(sprite.col) + 256 - int'(d);
         sprite.col = (skip_to > int'(trsd_pkg::ColMax)) ? trsd_pkg::ColMax : 9'(skip_to);
      end else if (d == 8'd0) begin
         sprite.col = 9'd0;
         sprite.row++;
      end else begin
         sprite.run = d[6:0];
      end

      // Resolve slots that need no byte: past the last row, past the row end.
      while (sprite.run != 7'd0) begin
         if (sprite.row >= img_height) begin
            sprite.leak = 1'b1;
            sprite.run  = 7'd0;
         end else if (int'(sprite.col) > int'(img_width)) begin
            sprite.row++;
            sprite.col  = 9'd0;
            sprite.leak = 1'b1;
            sprite.run--;
         end else if (int'(sprite.col) == int'(img_width)) begin
            sprite.leak = 1'b1;
            sprite.run  = 7'd0;
         end else begin
            break;
         end
      end

      if (wrote) begin
         res = make_beat(1'b1, pos, int'(d), 1'b0, int'(sprite.count[23:0]), sprite.leak,
                         sprite.ended);
         return 1'b1;
      end
      if (sprite.run == 7'd0 && sprite.row >= img_height) begin
         sprite.done = 1'b1;
         res = make_beat(1'b0, 0, 0, 1'b1, int'(sprite.count[23:0]), sprite.leak,
                         sprite.ended);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Fill the burst queue with one sprite of the given shape and style.
   function automatic void compose_sprite(int w, int h, sprite_style_type style);
      int col;
      int room;
      int n;
      int segs;
      int cut;
      bit sparse;
      burst.delete();
      if (style == SPRITE_NOISE) begin
         repeat ($urandom_range(4, 40))
            burst.push_back(beat_of($urandom_range(0, 255), $urandom_range(0, 15) == 0,
                                    $urandom_range(0, 7) == 0));
      end else begin
         for (int r = 0; r < h; r++) begin
            col = 0;
            // Tall sprites get mostly skip-only rows to keep them short.
            sparse = (h > 40) && ($urandom_range(0, 15) != 0);
            segs = sparse ? $urandom_range(0, 1) : $urandom_range(0, 4);
            repeat (segs) begin
               room = w - col;
               if (room > 0 && (sparse || $urandom_range(0, 2) == 0)) begin
                  n = $urandom_range(1, (room > 128) ? 128 : room);
                  burst.push_back(beat_of(256 - n, 1'b0, 1'b0));
                  col += n;
               end else if (room > 0 || style == SPRITE_OVERRUN) begin
                  n = (room > 127) ? 127 : room;
                  n = (n < 1) ? 1 : $urandom_range(1, n);
                  if (style == SPRITE_OVERRUN && $urandom_range(0, 1) == 0)
                     n = room + $urandom_range(1, 3);
                  n = (n > 127) ? 127 : ((n < 1) ? 1 : n);
                  burst.push_back(beat_of(n, 1'b0, 1'b0));
                  repeat (n) burst.push_back(beat_of($urandom_range(0, 255), 1'b0, 1'b0));
                  col += n;
               end
            end
            burst.push_back(beat_of(0, 1'b0, 1'b0));
         end
         // Cut the buffer short and read on past its end.
         if (style == SPRITE_TRUNCATED) begin
            cut = $urandom_range(1, burst.size());
            while (burst.size() > cut) void'(burst.pop_back());
            repeat (h + 2) burst.push_back(beat_of($urandom_range(0, 255), 1'b1, 1'b0));
         end
      end
      burst[0].first = 1'b1;
      // A few stray bytes after the sprite, dropped once it has finished.
      repeat ($urandom_range(0, 2))
         burst.push_back(beat_of($urandom_range(0, 255), $urandom_range(0, 1), 1'b0));
   endfunction

   task automatic flag_mismatch(string what);
      mismatches++;
      $display("%0t mismatch at result %0d: %s", $time, beats_taken, what);
   endtask

   task automatic compare_field(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Offer one stream beat, hold it until accepted, then run the model on it.
   // Valid stays high into the next beat unless an idle gap is drawn.
   task automatic send_byte(input stream_beat_type b, output bit emits,
                            output trsd_pkg::result_type res);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(0, 99) < IdlePercent) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= b.data;
      req_bus.beyond_end     <= b.beyond;
      req_bus.first_of_image <= b.first;
      do @(posedge clock); while (!req_bus.ready);
      emits = decode_byte(b, res);
      live_beats++;
      calm = (live_beats >= 500) && (live_beats < 800);
   endtask

   // Drop valid and wait until every owed beat is in, then wait on for a byte that
   // is still in flight without a result.
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (owed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == trsd_pkg::CsrImageWidth) img_width = value;
      else img_height = value;
      @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Result side: check each accepted beat, stall at random, and once hold
   // ready low for a long stretch so the decoder fills and stalls its input.
   // --------------------------------------------------------------------------
   initial begin : result_sink
      int                   hold_left;
      bit                   held;
      trsd_pkg::result_type got;
      trsd_pkg::result_type want;
      hold_left = 0;
      held      = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.pixel_write, rsp_bus.pixel_index, rsp_bus.colour_index,
                   rsp_bus.image_done, rsp_bus.bytes_consumed, rsp_bus.colour_leak,
                   rsp_bus.buffer_end};
            if (owed.size() == 0) begin
               flag_mismatch("result beat with nothing owed");
            end else begin
               want = owed.pop_front();
               compare_field("pixel_write", 24'(got.pixel_write), 24'(want.pixel_write));
               compare_field("pixel_index", 24'(got.pixel_index), 24'(want.pixel_index));
               compare_field("colour_index", 24'(got.colour_index), 24'(want.colour_index));
               compare_field("image_done", 24'(got.image_done), 24'(want.image_done));
               compare_field("bytes_consumed", got.bytes_consumed, want.bytes_consumed);
               compare_field("colour_leak", 24'(got.colour_leak), 24'(want.colour_leak));
               compare_field("buffer_end", 24'(got.buffer_end), 24'(want.buffer_end));
            end
            beats_taken++;
         end
         if (!held && beats_taken >= 300) begin
            held      = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IdlePercent);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      bit                   emits;
      trsd_pkg::result_type res;
      int                   w;
      int                   h;
      int                   pick;
      int                   cut;
      int                   guard;
      bit                   retune;
      bit                   split;
      sprite_style_type     style;

      live_beats  = 0;
      beats_taken = 0;
      mismatches  = 0;
      calm        = 1'b0;
      img_width   = 8'd1;
      img_height  = 8'd1;
      sprite      = '0;

      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= 8'd0;
      req_bus.beyond_end     <= 1'b0;
      req_bus.first_of_image <= 1'b0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= trsd_pkg::CsrImageWidth;
      csr_bus.data           <= 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size is 1x1: one literal, end of row, then the done beat.
      script.push_back('{ROW_QUIET, 8'h01, 1'b0, 1'b1, '0});
      script.push_back('{ROW_KNOWN, 8'hFF, 1'b0, 1'b0,
                         make_beat(1'b1, 0, 8'hFF, 1'b0, 2, 1'b0, 1'b0)});
      script.push_back('{ROW_KNOWN, 8'h00, 1'b0, 1'b0,
                         make_beat(1'b0, 0, 0, 1'b1, 3, 1'b0, 1'b0)});
      // Byte after the done beat: dropped.
      script.push_back('{ROW_QUIET, 8'h55, 1'b0, 1'b0, '0});
      // Run of two on a buffer that runs dry at once: the first slot fills without
      // a write, the second is swallowed at the row end, a zero acts as end of row.
      script.push_back('{ROW_QUIET, 8'h02, 1'b0, 1'b1, '0});
      script.push_back('{ROW_QUIET, 8'h80, 1'b1, 1'b0, '0});
      script.push_back('{ROW_KNOWN, 8'h7F, 1'b1, 1'b0,
                         make_beat(1'b0, 0, 0, 1'b1, 3, 1'b1, 1'b1)});
      // Largest sprite: skip far enough to saturate the column, then a run
      // that wraps to the next row.
      script.push_back('{ROW_SET_WIDTH, 8'd255, 1'b0, 1'b0, '0});
      script.push_back('{ROW_SET_HEIGHT, 8'd255, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h80, 1'b0, 1'b1, '0});
      script.push_back('{ROW_PREDICT, 8'h80, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h80, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h80, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h01, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h03, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h00, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'hAA, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h5A, 1'b1, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h00, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h05, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h12, 1'b0, 1'b0, '0});
      // Shrink the height under the current row with a run pending: the
      // next byte is not taken and the done beat carries the leak.
      script.push_back('{ROW_SET_HEIGHT, 8'd2, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h33, 1'b0, 1'b0, '0});
      // Narrow sprite: longest run overruns the row, skip past the end, then
      // a run that starts beyond the width and wraps.
      script.push_back('{ROW_SET_WIDTH, 8'd3, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h7F, 1'b0, 1'b1, '0});
      script.push_back('{ROW_PREDICT, 8'h11, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h22, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h33, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'hFF, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h01, 1'b0, 1'b0, '0});
      script.push_back('{ROW_PREDICT, 8'h00, 1'b0, 1'b0, '0});

      foreach (script[i]) begin
         case (script[i].kind)
            ROW_SET_WIDTH: begin
               settle_block();
               write_reg(trsd_pkg::CsrImageWidth, script[i].data);
            end
            ROW_SET_HEIGHT: begin
               settle_block();
               write_reg(trsd_pkg::CsrImageHeight, script[i].data);
            end
            default: begin
               send_byte(beat_of(script[i].data, script[i].beyond, script[i].first),
                         emits, res);
               if (script[i].kind == ROW_KNOWN) owed.push_back(script[i].want);
               else if (script[i].kind == ROW_PREDICT && emits) owed.push_back(res);
            end
         endcase
      end

      // Random sprites. Most are well formed; some overrun their rows, run
      // off the buffer end or are plain noise. Sizes change now and then
      // between sprites, and sometimes in the middle of one.
      live_beats = 0;
      while (live_beats < StreamTarget) begin
         case ($urandom_range(0, 9))
            0: w = 1;
            1: w = 255;
            2: w = $urandom_range(1, 255);
            default: w = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 9))
            0: h = 1;
            1: h = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 40);
            default: h = $urandom_range(1, 5);
         endcase
         pick = $urandom_range(0, 9);
         style = (pick < 6) ? SPRITE_CLEAN :
                 (pick == 6) ? SPRITE_OVERRUN :
                 (pick < 9) ? SPRITE_TRUNCATED : SPRITE_NOISE;
         retune = $urandom_range(0, 2) == 0;
         split  = retune && ($urandom_range(0, 3) == 0);
         if (retune && !split) begin
            settle_block();
            write_reg(trsd_pkg::CsrImageWidth, 8'(w));
            write_reg(trsd_pkg::CsrImageHeight, 8'(h));
         end
         compose_sprite(img_width, img_height, style);
         cut = split ? $urandom_range(1, burst.size()) : burst.size();
         foreach (burst[i]) begin
            // Stop mid-sprite once enough bytes have gone in.
            if (live_beats >= StreamTarget) break;
            // Mid-sprite resize: drain first, then write both sizes.
            if (i == cut) begin
               settle_block();
               write_reg(trsd_pkg::CsrImageWidth, 8'(w));
               write_reg(trsd_pkg::CsrImageHeight, 8'(h));
            end
            send_byte(burst[i], emits, res);
            if (emits) owed.push_back(res);
         end
      end

      // Drain, bounded; anything still owed afterwards is a failure.
      req_bus.valid <= 1'b0;
      for (guard = 0; guard < 4000 && owed.size() != 0; guard++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (owed.size() != 0)
         flag_mismatch($sformatf("%0d result beats never arrived", owed.size()));

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/trsd_pkg.sv
hw/rtl/trsd_channels.sv
hw/rtl/transparent_rle_sprite_decoder.sv
sim/tb.sv
